>>> sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants
// Pipeline word, fixed-point constants and the divider step used by the
// soil thermal conductivity pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam logic [15:0] ONE15          = 16'd32768;
	localparam logic [15:0] SAT_TENTH      = 16'd3277;
	localparam logic [16:0] LOG2_ICE_Q16   = 17'd74547;
	// magnitude of log2(0.57) in Q16, applied with negative sign
	localparam logic [15:0] LOG2_WATER_Q16 = 16'd53147;
	localparam logic [29:0] LN2_Q30        = 30'd744261118;
	localparam logic [28:0] LOG10_2_Q30    = 29'd323228497;
	localparam logic [31:0] Q30            = 32'h4000_0000;
	localparam int          EXP_BIAS       = 16;
	localparam int          N_MAX          = 4;
	localparam int          KSAT_SHIFT0    = 18;

	localparam int QUOT_BITS      = 16;
	localparam int DIV_STEP_BITS  = 2;
	localparam int DIV_STAGES     = QUOT_BITS / DIV_STEP_BITS;
	localparam int HORNER_TERMS   = 9;
	localparam int SQ_STEPS       = 16;

	typedef struct packed {
		logic               zero;
		logic               fdep_nz;
		logic               clip;
		logic [15:0]        kdry;
		logic [17:0]        depth;
		logic [17:0]        wsat;
		logic [35:0]        num;
		logic               big_p;
		logic               big_f;
		logic               big_s;
		logic [17:0]        rem_p;
		logic [17:0]        rem_f;
		logic [17:0]        rem_s;
		logic [15:0]        nb_p;
		logic [15:0]        nb_f;
		logic [15:0]        nb_s;
		logic [15:0]        q_p;
		logic [15:0]        q_f;
		logic [15:0]        q_s;
		logic [16:0]        pf;
		logic [33:0]        pfi;
		logic signed [17:0] pq;
		logic signed [40:0] esum;
		logic [15:0]        frac;
		logic [5:0]         shift;
		logic [29:0]        y;
		logic [31:0]        r;
		logic [31:0]        t;
		logic [31:0]        qe;
		logic [15:0]        ksat;
		logic               direct;
		logic [3:0]         lint;
		logic [31:0]        m;
		logic [15:0]        lfrac;
		logic [19:0]        lneg;
		logic [18:0]        d;
		logic [15:0]        ke;
		logic [32:0]        pa;
		logic [31:0]        pb;
		logic [15:0]        cond;
	} pipe_t;

	function automatic logic [18:0] div_step(input logic [17:0] rem, input logic nbit,
			input logic [17:0] den);
		logic [18:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, den}) begin
			div_step = {1'b1, 18'(t - {1'b0, den})};
		end else begin
			div_step = {1'b0, t[17:0]};
		end
	endfunction

	function automatic pipe_t div_advance(input pipe_t p);
		pipe_t       o;
		logic [18:0] a;
		o = p;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			a = div_step(o.rem_p, o.nb_p[15], o.depth);
			o.rem_p = a[17:0];
			o.q_p   = {o.q_p[14:0], a[18]};
			o.nb_p  = {o.nb_p[14:0], 1'b0};
			a = div_step(o.rem_f, o.nb_f[15], o.depth);
			o.rem_f = a[17:0];
			o.q_f   = {o.q_f[14:0], a[18]};
			o.nb_f  = {o.nb_f[14:0], 1'b0};
			a = div_step(o.rem_s, o.nb_s[15], o.wsat);
			o.rem_s = a[17:0];
			o.q_s   = {o.q_s[14:0], a[18]};
			o.nb_s  = {o.nb_s[14:0], 1'b0};
		end
		return o;
	endfunction

endpackage

>>> sv/stc_prep.sv
// ----------------------------------------------------------------------------
// stc_prep: request capture
// Registers a request, forms the saturation numerator and sets up the
// three dividers with their overflow flags.
// ----------------------------------------------------------------------------
module stc_prep import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [17:0] layer_depth,
	input  logic [17:0] saturation_water,
	input  logic [17:0] holding_capacity,
	input  logic [17:0] wilting_water,
	input  logic [15:0] relative_water,
	input  logic [17:0] ice_amount,
	input  logic [17:0] free_water,
	input  logic [17:0] free_ice,
	input  logic [17:0] frozen_depth,
	input  logic [15:0] dry_conductivity,
	output logic        out_vld,
	output pipe_t       out_p
);

	pipe_t      p1_n, p2_n;
	pipe_t      p1_s, p2_s;
	logic       vld_s1, vld_s2;
	logic [19:0] amt_sum;

	always_comb begin
		amt_sum = 20'(ice_amount) + 20'(wilting_water) + 20'(free_water) + 20'(free_ice);
		p1_n = '0;
		p1_n.zero    = (layer_depth == '0) || (saturation_water == '0);
		p1_n.fdep_nz = (frozen_depth != '0);
		p1_n.kdry    = dry_conductivity;
		p1_n.depth   = layer_depth;
		p1_n.wsat    = saturation_water;
		p1_n.num     = 36'(relative_water) * 36'(holding_capacity) + (36'(amt_sum) << 15);
		p1_n.big_p   = {1'b0, saturation_water} >= {layer_depth, 1'b0};
		p1_n.rem_p   = {1'b0, saturation_water[17:1]};
		p1_n.nb_p    = {saturation_water[0], 15'b0};
		p1_n.big_f   = {1'b0, frozen_depth} >= {layer_depth, 1'b0};
		p1_n.rem_f   = {1'b0, frozen_depth[17:1]};
		p1_n.nb_f    = {frozen_depth[0], 15'b0};
	end

	always_comb begin
		p2_n = p1_s;
		p2_n.big_s = p1_s.num >= ((36'(p1_s.wsat) << 15) + 36'(p1_s.wsat));
		p2_n.rem_s = p1_s.num[33:16];
		p2_n.nb_s  = p1_s.num[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s <= p1_n;
			p2_s <= p2_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign out_p   = p2_s;

endmodule

>>> sv/stc_div.sv
// ----------------------------------------------------------------------------
// stc_div: pipelined restoring dividers
// Porosity, frozen share and saturation quotients, two bits per stage.
// ----------------------------------------------------------------------------
module stc_div import stc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  pipe_t in_p,
	output logic  out_vld,
	output pipe_t out_p
);

	pipe_t                 dv_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_s;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		pipe_t src;
		if (g == 0) begin : g_head
			assign src = in_p;
		end else begin : g_tail
			assign src = dv_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[g] <= div_advance(src);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STAGES-2:0], in_vld};
		end
	end

	assign out_vld = vld_s[DIV_STAGES-1];
	assign out_p   = dv_s[DIV_STAGES-1];

endmodule

>>> sv/stc_expo.sv
// ----------------------------------------------------------------------------
// stc_expo: saturated conductivity
// Log2 exponent sum, Horner series for 2^frac and the final scaling shift.
// ----------------------------------------------------------------------------
module stc_expo import stc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  pipe_t in_p,
	output logic  out_vld,
	output pipe_t out_p
);

	localparam int EXPO_LAT = 5 + 3 * HORNER_TERMS + 1;

	pipe_t               e1_n, e2_n, e3_n, e4_n, e5_n, e6_n;
	pipe_t               e1_s, e2_s, e3_s, e4_s, e5_s, e6_s;
	pipe_t               h1_s [HORNER_TERMS];
	pipe_t               h2_s [HORNER_TERMS];
	pipe_t               h3_s [HORNER_TERMS];
	logic [EXPO_LAT-1:0] vld_s;
	logic [40:0]         ub;
	logic [4:0]          nraw;
	logic [39:0]         rnd;

	always_comb begin
		e1_n = in_p;
		e1_n.q_p  = in_p.big_p ? 16'hFFFF : in_p.q_p;
		e1_n.q_f  = in_p.big_f ? 16'hFFFF : in_p.q_f;
		e1_n.q_s  = in_p.big_s ? ONE15 : in_p.q_s;
		e1_n.clip = in_p.clip | in_p.big_s;
		e1_n.pf   = 17'((32'(e1_n.q_p) * 32'(e1_n.q_f)) >> 15);
	end

	always_comb begin
		e2_n = e1_s;
		e2_n.pq  = $signed(18'({2'b00, e1_s.q_p}) - 18'({1'b0, e1_s.pf}));
		e2_n.pfi = 34'(e1_s.pf) * 34'(LOG2_ICE_Q16);
	end

	always_comb begin
		e3_n = e2_s;
		e3_n.esum = ((($signed(41'(ONE15)) - $signed(41'(e2_s.q_p))) * 41'sd3) <<< 16)
			+ $signed(41'(e2_s.pfi))
			- 41'(e2_s.pq) * $signed(41'(LOG2_WATER_Q16));
	end

	always_comb begin
		e4_n = e3_s;
		ub   = 41'(e3_s.esum) + (41'(EXP_BIAS) << 31) + (41'd1 << 14);
		nraw = ub[35:31];
		e4_n.frac  = ub[30:15];
		e4_n.shift = (nraw > 5'(EXP_BIAS + N_MAX)) ? 6'(KSAT_SHIFT0 - N_MAX)
			: 6'(KSAT_SHIFT0 + EXP_BIAS) - 6'(nraw);
	end

	always_comb begin
		e5_n = e4_s;
		e5_n.y = 30'((46'(e4_s.frac) * 46'(LN2_Q30)) >> 16);
		e5_n.r = Q30;
	end

	for (genvar g = 0; g < HORNER_TERMS; g++) begin : g_term
		localparam int K = HORNER_TERMS - g;
		pipe_t       src, a_n, b_n, c_n;
		logic [35:0] rem_w;
		if (g == 0) begin : g_head
			assign src = e5_s;
		end else begin : g_tail
			assign src = h3_s[g-1];
		end

		always_comb begin
			a_n = src;
			a_n.t = 32'((64'(src.r) * 64'(src.y)) >> 30);
		end

		if ((K & (K - 1)) == 0) begin : g_pow2
			always_comb begin
				b_n = h1_s[g];
				b_n.qe = h1_s[g].t >> $clog2(K);
			end
		end else begin : g_recip
			localparam logic [31:0] M = 32'((64'd1 << 33) / K);
			always_comb begin
				b_n = h1_s[g];
				b_n.qe = 32'((64'(h1_s[g].t) * 64'(M)) >> 33);
			end
		end

		always_comb begin
			c_n   = h2_s[g];
			rem_w = 36'(h2_s[g].t) - 36'(h2_s[g].qe) * 36'(K);
			c_n.r = Q30 + h2_s[g].qe + 32'(rem_w >= 36'(K));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				h1_s[g] <= a_n;
				h2_s[g] <= b_n;
				h3_s[g] <= c_n;
			end
		end
	end

	always_comb begin
		e6_n = h3_s[HORNER_TERMS-1];
		rnd  = (40'(h3_s[HORNER_TERMS-1].r) + (40'd1 << (h3_s[HORNER_TERMS-1].shift - 6'd1)))
			>> h3_s[HORNER_TERMS-1].shift;
		e6_n.ksat = (|rnd[39:16]) ? 16'hFFFF : rnd[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s <= e1_n;
			e2_s <= e2_n;
			e3_s <= e3_n;
			e4_s <= e4_n;
			e5_s <= e5_n;
			e6_s <= e6_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[EXPO_LAT-2:0], in_vld};
		end
	end

	assign out_vld = vld_s[EXPO_LAT-1];
	assign out_p   = e6_s;

endmodule

>>> sv/stc_logk.sv
// ----------------------------------------------------------------------------
// stc_logk: Kersten number
// Normalize, square for the log2 fraction bits, scale to log10 and select.
// ----------------------------------------------------------------------------
module stc_logk import stc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  pipe_t in_p,
	output logic  out_vld,
	output pipe_t out_p
);

	localparam int LOG_LAT = 1 + SQ_STEPS + 3;

	pipe_t              l1_n, l18_n, l19_n, l20_n;
	pipe_t              l1_s, l18_s, l19_s, l20_s;
	pipe_t              sq_s [SQ_STEPS];
	logic [LOG_LAT-1:0] vld_s;
	logic [3:0]         lint;

	function automatic pipe_t sq_step(input pipe_t p);
		pipe_t       o;
		logic [31:0] sq;
		o  = p;
		sq = 32'((64'(p.m) * 64'(p.m)) >> 30);
		if (sq[31]) begin
			o.m     = {1'b0, sq[31:1]};
			o.lfrac = {p.lfrac[14:0], 1'b1};
		end else begin
			o.m     = sq;
			o.lfrac = {p.lfrac[14:0], 1'b0};
		end
		return o;
	endfunction

	always_comb begin
		lint = 4'd15;
		for (int i = 0; i < 16; i++) begin
			if (in_p.q_s[i]) begin
				lint = 4'(15 - i);
			end
		end
		l1_n = in_p;
		l1_n.direct = in_p.fdep_nz || (in_p.q_s < SAT_TENTH);
		l1_n.lint   = lint;
		l1_n.m      = 32'({in_p.q_s, 15'b0}) << lint;
		l1_n.lfrac  = '0;
	end

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
		pipe_t src;
		if (g == 0) begin : g_head
			assign src = l1_s;
		end else begin : g_tail
			assign src = sq_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g] <= sq_step(src);
			end
		end
	end

	always_comb begin
		l18_n = sq_s[SQ_STEPS-1];
		l18_n.lneg = {sq_s[SQ_STEPS-1].lint, 16'b0} - 20'(sq_s[SQ_STEPS-1].lfrac);
	end

	always_comb begin
		l19_n = l18_s;
		l19_n.d = 19'((50'(l18_s.lneg) * 50'(LOG10_2_Q30) + (50'd1 << 30)) >> 31);
	end

	always_comb begin
		l20_n = l19_s;
		if (l19_s.direct) begin
			l20_n.ke = l19_s.q_s;
		end else if (l19_s.d >= 19'(ONE15)) begin
			l20_n.ke = '0;
		end else begin
			l20_n.ke = 16'(19'(ONE15) - l19_s.d);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l1_s  <= l1_n;
			l18_s <= l18_n;
			l19_s <= l19_n;
			l20_s <= l20_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LOG_LAT-2:0], in_vld};
		end
	end

	assign out_vld = vld_s[LOG_LAT-1];
	assign out_p   = l20_s;

endmodule

>>> sv/soil_thermal_conductivity_johansen_top.sv
// ----------------------------------------------------------------------------
// soil_thermal_conductivity_johansen_top: soil layer thermal conductivity
// Takes one request per cycle and returns one conductivity result per
// request. The whole pipeline holds while out_stall is high with a
// result waiting; in_stall follows that hold. Latency is mostly set by
// the Horner series for 2^frac (nine terms of three stages each), the
// sixteen squaring stages of the log2 unit and the eight divider stages.
// ----------------------------------------------------------------------------
module soil_thermal_conductivity_johansen_top import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [17:0] layer_depth,
	input  logic [17:0] saturation_water,
	input  logic [17:0] holding_capacity,
	input  logic [17:0] wilting_water,
	input  logic [15:0] relative_water,
	input  logic [17:0] ice_amount,
	input  logic [17:0] free_water,
	input  logic [17:0] free_ice,
	input  logic [17:0] frozen_depth,
	input  logic [15:0] dry_conductivity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] conductivity,
	output logic        clipped,
	output logic        bad_divisor
);

	logic        en;
	logic        prep_vld, div_vld, expo_vld, log_vld;
	pipe_t       prep_p, div_p, expo_p, log_p;
	pipe_t       b1_n, b2_n;
	pipe_t       b1_s, b2_s;
	logic        vld_s1, vld_s2;
	logic [16:0] wgt;
	logic [33:0] acc;

	assign en       = !(vld_s2 && out_stall);
	assign in_stall = !en;

	stc_prep u_prep (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_vld           (in_valid),
		.layer_depth      (layer_depth),
		.saturation_water (saturation_water),
		.holding_capacity (holding_capacity),
		.wilting_water    (wilting_water),
		.relative_water   (relative_water),
		.ice_amount       (ice_amount),
		.free_water       (free_water),
		.free_ice         (free_ice),
		.frozen_depth     (frozen_depth),
		.dry_conductivity (dry_conductivity),
		.out_vld          (prep_vld),
		.out_p            (prep_p)
	);

	stc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (prep_vld),
		.in_p    (prep_p),
		.out_vld (div_vld),
		.out_p   (div_p)
	);

	stc_expo u_expo (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.in_p    (div_p),
		.out_vld (expo_vld),
		.out_p   (expo_p)
	);

	stc_logk u_logk (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (expo_vld),
		.in_p    (expo_p),
		.out_vld (log_vld),
		.out_p   (log_p)
	);

	always_comb begin
		b1_n = log_p;
		wgt  = 17'(ONE15) - 17'(log_p.ke);
		b1_n.pa = 33'(log_p.kdry) * 33'(wgt);
		b1_n.pb = 32'(log_p.ksat) * 32'(log_p.ke);
	end

	always_comb begin
		b2_n = b1_s;
		acc  = 34'(b1_s.pa) + 34'(b1_s.pb) + (34'd1 << 14);
		if (b1_s.zero) begin
			b2_n.cond = b1_s.kdry;
			b2_n.clip = 1'b0;
		end else if (|acc[33:31]) begin
			b2_n.cond = 16'hFFFF;
			b2_n.clip = 1'b1;
		end else begin
			b2_n.cond = acc[30:15];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b1_s <= b1_n;
			b2_s <= b2_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= log_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid    = vld_s2;
	assign conductivity = b2_s.cond;
	assign clipped      = b2_s.clip;
	assign bad_divisor  = b2_s.zero;

`ifndef SYNTHESIS
	a_bad_not_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_divisor |-> !clipped)
		else $error("clip flagged on a zero-divisor result");
	a_front_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall |=> prep_vld)
		else $error("accepted request lost in front stages");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !vld_s1 |=> !out_valid)
		else $error("result repeated after delivery");
`endif

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: soil layer thermal conductivity
// Drives layer requests through a table of directed cases and then random
// well-formed and extreme layers, with random idling on both handshakes, and
// checks every result against a fixed-point model of the Johansen scheme.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1350;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	localparam longint unsigned ONE_Q15 = 64'd32768;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned LN2_FX = 64'd744261118;
	localparam longint unsigned LOG10_2_FX = 64'd323228497;
	localparam longint signed ICE_LOG_FX = 74547;
	localparam longint signed WATER_LOG_FX = -53147;
	localparam int TENTH_Q15 = 3277;

	typedef struct {
		logic [17:0] depth;
		logic [17:0] wsat;
		logic [17:0] whc;
		logic [17:0] wpwp;
		logic [15:0] relw;
		logic [17:0] ice;
		logic [17:0] fw;
		logic [17:0] fi;
		logic [17:0] fdep;
		logic [15:0] kdry;
	} layer_t;

	typedef struct {
		logic [15:0] cond;
		logic clip;
		logic bad;
	} cond_t;

	typedef struct {
		layer_t layer;
		bit known;
		cond_t cond;
	} case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [17:0] layer_depth = '0;
	logic [17:0] saturation_water = '0;
	logic [17:0] holding_capacity = '0;
	logic [17:0] wilting_water = '0;
	logic [15:0] relative_water = '0;
	logic [17:0] ice_amount = '0;
	logic [17:0] free_water = '0;
	logic [17:0] free_ice = '0;
	logic [17:0] frozen_depth = '0;
	logic [15:0] dry_conductivity = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] conductivity;
	logic clipped;
	logic bad_divisor;

	cond_t pending_conds[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	int stall_left = 0;

	always #6 clk = ~clk;

	soil_thermal_conductivity_johansen_top dut (.*);

	function automatic longint unsigned q15_ratio(longint unsigned x, longint unsigned d);
		longint unsigned q;
		q = (x << 15) / d;
		return q > 65535 ? 65535 : q;
	endfunction

	function automatic longint unsigned pow2_frac_q30(longint unsigned frac);
		longint unsigned y, r;
		y = (frac * LN2_FX) >> 16;
		r = ONE_Q30;
		for (int k = 9; k >= 1; k--)
			r = ONE_Q30 + ((r * y) >> 30) / k;
		return r;
	endfunction

	function automatic longint unsigned minus_log2_q16(int unsigned s);
		int b;
		longint unsigned m, frac;
		b = 15;
		frac = 0;
		while (b > 0 && s[b] == 1'b0)
			b--;
		m = longint'(s) << (30 - b);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 2 * ONE_Q30) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(15 - b) << 16) - frac;
	endfunction

	function automatic cond_t conductivity_of(layer_t l);
		cond_t o;
		longint unsigned por, fz, u16, r, ksat, num, q, res, d, ke;
		longint signed pf, pq, esum;
		int n;
		o.clip = 1'b0;
		o.bad = 1'b0;
		if (l.depth == 0 || l.wsat == 0) begin
			o.cond = l.kdry;
			o.bad = 1'b1;
			return o;
		end
		por = q15_ratio(l.wsat, l.depth);
		fz = q15_ratio(l.fdep, l.depth);
		pf = longint'((por * fz) >> 15);
		pq = longint'(por) - pf;
		esum = 3 * (longint'(ONE_Q15) - longint'(por)) * 65536
			+ pf * ICE_LOG_FX + pq * WATER_LOG_FX;
		u16 = (longint'(esum + (longint'(16) << 31)) + (1 << 14)) >> 15;
		n = int'(u16 >> 16) - 16;
		if (n > 4) n = 4;
		if (n < -20) n = -20;
		r = pow2_frac_q30(u16 & 16'hFFFF);
		ksat = (r + (64'd1 << (17 - n))) >> (18 - n);
		if (ksat > 65535) ksat = 65535;
		num = longint'(l.relw) * l.whc
			+ ((longint'(l.ice) + l.wpwp + l.fw + l.fi) << 15);
		q = num / l.wsat;
		if (q > ONE_Q15) begin
			q = ONE_Q15;
			o.clip = 1'b1;
		end
		if (l.fdep != 0 || q < TENTH_Q15) begin
			ke = q;
		end else begin
			d = (minus_log2_q16(32'(q)) * LOG10_2_FX + ONE_Q30) >> 31;
			ke = d >= ONE_Q15 ? 0 : ONE_Q15 - d;
		end
		res = (longint'(l.kdry) * (ONE_Q15 - ke) + ksat * ke + (1 << 14)) >> 15;
		if (res > 65535) begin
			res = 65535;
			o.clip = 1'b1;
		end
		o.cond = 16'(res);
		return o;
	endfunction

	function automatic layer_t mk(int depth, int wsat, int whc, int wpwp, int relw,
			int ice, int fw, int fi, int fdep, int kdry);
		layer_t l;
		l.depth = 18'(depth);
		l.wsat = 18'(wsat);
		l.whc = 18'(whc);
		l.wpwp = 18'(wpwp);
		l.relw = 16'(relw);
		l.ice = 18'(ice);
		l.fw = 18'(fw);
		l.fi = 18'(fi);
		l.fdep = 18'(fdep);
		l.kdry = 16'(kdry);
		return l;
	endfunction

	function automatic layer_t random_layer();
		layer_t l;
		int unsigned mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			l = mk($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (mode == 1) begin
			l = mk($urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3), $urandom);
			if ($urandom_range(0, 1)) l.depth = 18'($urandom);
		end else begin
			l.depth = 18'($urandom_range(1000, 262143));
			l.wsat = 18'($urandom_range(1, l.depth));
			l.whc = 18'($urandom_range(0, l.wsat));
			l.wpwp = 18'($urandom_range(0, l.wsat / 4));
			l.relw = 16'($urandom_range(0, 32768));
			l.ice = 18'($urandom_range(0, 1) ? 0 : $urandom_range(0, l.wsat / 2));
			l.fw = 18'($urandom_range(0, l.wsat / 8));
			l.fi = 18'($urandom_range(0, 1) ? 0 : $urandom_range(0, l.wsat / 8));
			l.fdep = 18'($urandom_range(0, 2) != 0 ? 0 : $urandom_range(1, l.depth));
			l.kdry = 16'($urandom);
			if (mode == 2) l.kdry = 16'($urandom_range(0, 2000));
		end
		return l;
	endfunction

	task automatic send_layer(layer_t l);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		layer_depth <= l.depth;
		saturation_water <= l.wsat;
		holding_capacity <= l.whc;
		wilting_water <= l.wpwp;
		relative_water <= l.relw;
		ice_amount <= l.ice;
		free_water <= l.fw;
		free_ice <= l.fi;
		frozen_depth <= l.fdep;
		dry_conductivity <= l.kdry;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cond_t want;
		if (in_valid && !in_stall)
			pending_conds.push_back(conductivity_of('{layer_depth, saturation_water,
				holding_capacity, wilting_water, relative_water, ice_amount, free_water,
				free_ice, frozen_depth, dry_conductivity}));
		if (out_valid && !out_stall) begin
			if (pending_conds.size() == 0) begin
				$display("%t: unexpected result cond=%0d clip=%b bad=%b", $realtime,
					conductivity, clipped, bad_divisor);
				errors++;
			end else begin
				want = pending_conds.pop_front();
				if (want.cond !== conductivity || want.clip !== clipped
						|| want.bad !== bad_divisor) begin
					$display("%t: mismatch expected cond=%0d clip=%b bad=%b actual cond=%0d clip=%b bad=%b",
						$realtime, want.cond, want.clip, want.bad, conductivity, clipped,
						bad_divisor);
					errors++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0) out_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17);
			out_stall <= 1'b1;
		end
	end

	initial begin
		case_t cases[$];
		cond_t first;
		cases.push_back('{mk(0, 1000, 5, 5, 5, 5, 5, 5, 5, 12345), 1, '{12345, 0, 1}});
		cases.push_back('{mk(1000, 0, 5, 5, 5, 5, 5, 5, 0, 65535), 1, '{65535, 0, 1}});
		cases.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 1}});
		cases.push_back('{mk(1000, 400, 400, 0, 32768, 0, 0, 0, 0, 1000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1000, 400, 0, 0, 0, 0, 0, 0, 0, 1000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1000, 400, 400, 20, 65535, 400, 400, 400, 0, 2000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1000, 400, 100, 20, 32768, 0, 0, 0, 0, 2000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1000, 400, 100, 30, 16384, 0, 0, 0, 500, 2000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1000, 400, 400, 0, 32768, 0, 0, 0, 1000, 2000), 0, '{0, 0, 0}});
		cases.push_back('{mk(1, 262143, 0, 0, 0, 0, 0, 0, 262143, 0), 0, '{0, 0, 0}});
		cases.push_back('{mk(262143, 1, 262143, 262143, 65535, 262143, 262143, 262143,
			262143, 65535), 0, '{0, 0, 0}});
		cases.push_back('{mk(262143, 262143, 262143, 262143, 65535, 262143, 262143,
			262143, 0, 65535), 0, '{0, 0, 0}});
		cases.push_back('{mk(100000, 50000, 1, 0, 1, 0, 0, 0, 0, 65535), 0, '{0, 0, 0}});
		cases.push_back('{mk(100000, 50000, 0, 5000, 0, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
		cases.push_back('{mk(100000, 100000, 100000, 0, 32768, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
		cases.push_back('{mk(170000, 85000, 0, 0, 0, 0, 0, 0, 0, 43690), 0, '{0, 0, 0}});
		cases.push_back('{mk(87381, 174762, 87381, 87381, 43690, 87381, 87381, 87381,
			87381, 21845), 0, '{0, 0, 0}});
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (cases[i]) begin
			if (cases[i].known) begin
				first = conductivity_of(cases[i].layer);
				if (first.cond != cases[i].cond.cond || first.clip != cases[i].cond.clip
						|| first.bad != cases[i].cond.bad) begin
					$display("%t: mismatch expected cond=%0d clip=%b bad=%b actual cond=%0d clip=%b bad=%b",
						$realtime, cases[i].cond.cond, cases[i].cond.clip, cases[i].cond.bad,
						first.cond, first.clip, first.bad);
					errors++;
				end
			end
			send_layer(cases[i].layer);
		end
		in_valid <= 1'b0;
		while (pending_conds.size() != 0) @(negedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM * 9 / 10) calm = 1'b1;
			send_layer(random_layer());
		end
		in_valid <= 1'b0;
		while (pending_conds.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
